>>> design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // pad character '='
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // alphabet anchors
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  // group queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one encoded group: four sextets, number of real characters, message end
  typedef struct packed {
    logic [23:0] sext;
    logic [2:0]  num_chars;
    logic        fin;
  } group_t;

  // map a 6-bit value onto the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = CHAR_SLASH;
    if (v < 6'd26) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < 6'd52) begin
      c = CHAR_LOWER_A + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = CHAR_ZERO + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = CHAR_PLUS;
    end
    return c;
  endfunction

endpackage

>>> design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Takes raw bytes, holds up to two pending bytes and emits one group entry
// per completed or final group of three.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  input  logic       q_full,
  output logic       q_push,
  output group_t     q_data
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] pend0_r, pend1_r;
  logic [1:0] cnt;
  logic       acc;
  logic       flush;
  logic [7:0] g0, g1, g2;

  // input transaction accepted whenever the queue has room
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // count three never arises; treat it as two
  assign cnt   = (cnt_r == 2'd3) ? 2'd2 : cnt_r;
  assign flush = (cnt == 2'd2) || in_is_final;

  // assemble the group, missing bytes zero
  always_comb begin
    g0 = (cnt == 2'd0) ? in_data_byte : pend0_r;
    g1 = 8'h00;
    g2 = 8'h00;
    if (cnt == 2'd1) begin
      g1 = in_data_byte;
    end else if (cnt == 2'd2) begin
      g1 = pend1_r;
      g2 = in_data_byte;
    end
  end

  // split into sextets
  always_comb begin
    q_data.sext      = {g0[7:2], g0[1:0], g1[7:4], g1[3:0], g2[7:6], g2[5:0]};
    q_data.num_chars = {1'b0, cnt} + 3'd2;
    q_data.fin       = in_is_final;
  end

  assign q_push = acc && flush;

  // count update
  always_comb begin
    cnt_nxt = cnt_r;
    if (acc) begin
      cnt_nxt = flush ? 2'd0 : cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // pending byte storage
  always_ff @(posedge clk) begin
    if (acc && !flush) begin
      if (cnt == 2'd0) begin
        pend0_r <= in_data_byte;
      end else begin
        pend1_r <= in_data_byte;
      end
    end
  end

endmodule

>>> design/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Short group queue that decouples the byte front from the character back.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output group_t head
);

  group_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks head group into output register, one character per unstalled cycle.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_not_empty,
  input  group_t     q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_code,
  output logic       out_end_of_text
);

  logic [1:0] idx_r, idx_nxt;
  logic       ovld_r, ovld_nxt;
  logic [7:0] ochar_r;
  logic       oend_r;
  logic       load;
  logic [5:0] sext;
  logic [7:0] ch;
  logic       last_ch;

  // output register free or being drained
  assign load = q_not_empty && (!ovld_r || !out_stall);

  // pick current sextet and character
  always_comb begin
    case (idx_r)
      2'd0:    sext = q_head.sext[23:18];
      2'd1:    sext = q_head.sext[17:12];
      2'd2:    sext = q_head.sext[11:6];
      default: sext = q_head.sext[5:0];
    endcase
    ch      = ({1'b0, idx_r} < q_head.num_chars) ? b64_char(sext) : PAD_CHAR;
    last_ch = (idx_r == 2'd3);
  end

  assign q_pop = load && last_ch;

  always_comb begin
    idx_nxt  = load ? idx_r + 2'd1 : idx_r;
    ovld_nxt = load || (ovld_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      ovld_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      ochar_r <= ch;
      oend_r  <= q_head.fin && last_ch;
    end
  end

  assign out_valid       = ovld_r;
  assign out_char_code   = ochar_r;
  assign out_end_of_text = oend_r;

endmodule

>>> design/base64_encoder.sv
// ----------------------------------------------------------------------------
// base64_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// Bytes enter one per transaction with a final flag on the last byte of a
// message; every third byte, or the final byte, yields four characters, the
// last character of a message flagged by out_end_of_text. The front never
// waits on the output except when the two-entry group queue is full, so it
// takes new bytes while the back is still writing out earlier groups. The
// back side writes one character per cycle into the output register while
// out_stall is low. A completed group is written into a queue entry, and
// its first character then into the output register.
// ----------------------------------------------------------------------------
module base64_encoder import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_code,
  output logic       out_end_of_text
);

  group_t push_data;
  group_t head;
  logic   push, full, pop, not_empty;

  // byte intake and grouping
  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_is_final  (in_is_final),
    .q_full       (full),
    .q_push       (push),
    .q_data       (push_data)
  );

  // group queue
  b64e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // character output
  b64e_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (not_empty),
    .q_head          (head),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_code   (out_char_code),
    .out_end_of_text (out_end_of_text)
  );

endmodule
